### hdl/sltq_pkg.sv
`timescale 1ns / 1ps

package sltq_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int LINE_DEPTH_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 16;

    // Request command codes.
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_ENQ  = 2'd2,
        CMD_DEQ  = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_STACK_EMPTY = 2'd1,
        ST_LINE_EMPTY  = 2'd2,
        ST_FULL        = 2'd3
    } status_t;

    // Fill flags that each store reports to the command decode.
    typedef struct packed {
        logic full;
        logic empty;
    } fill_t;

endpackage

### hdl/sltq_stack.sv
`timescale 1ns / 1ps

module sltq_stack
    import sltq_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int WIDTH = VALUE_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_en,
    input  logic             pop_en,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata,
    output fill_t            fill
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    top_idx;
    logic [WIDTH-1:0] rdata_reg;

    assign top_idx    = count_reg - CW'(1);
    assign fill.full  = (count_reg == CW'(DEPTH));
    assign fill.empty = (count_reg == '0);
    assign rdata      = rdata_reg;

    always_comb begin
        count_next = count_reg;
        if (push_en) begin
            count_next = count_reg + CW'(1);
        end else if (pop_en) begin
            count_next = top_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Store array: write at the free slot, read the top on pop.
    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[count_reg[AW-1:0]] <= wdata;
        end
        if (pop_en) begin
            rdata_reg <= mem[top_idx[AW-1:0]];
        end
    end

endmodule

### hdl/sltq_line.sv
`timescale 1ns / 1ps

module sltq_line
    import sltq_pkg::*;
#(
    parameter int DEPTH = LINE_DEPTH_DEF,
    parameter int WIDTH = VALUE_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             enq_en,
    input  logic             deq_en,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata,
    output fill_t            fill
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [AW-1:0]    tail_reg;
    logic [AW-1:0]    tail_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [WIDTH-1:0] rdata_reg;

    assign fill.full  = (count_reg == CW'(DEPTH));
    assign fill.empty = (count_reg == '0);
    assign rdata      = rdata_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (enq_en) begin
            tail_next  = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
            count_next = count_reg + CW'(1);
        end else if (deq_en) begin
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (enq_en) begin
            mem[tail_reg] <= wdata;
        end
        if (deq_en) begin
            rdata_reg <= mem[head_reg];
        end
    end

endmodule

### hdl/stack_and_two_line_queue_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                                        Accepted when
// request   in         s_cmd, s_line_select, s_plate_value          s_valid & s_ready
// result    out        m_status, m_data_out, m_data_valid           m_valid & m_ready
//
// One result per request, valid in the cycle after acceptance.
// A request is taken every cycle while the result register is empty or draining.
// A stalled result holds the store read registers and blocks new requests.
// Synchronous active-low reset clears all counts, pointers and the held value;
// store contents are not cleared and need no clearing pass.

module stack_and_two_line_queue_unit
    import sltq_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic        s_line_select,
    input  logic [15:0] s_plate_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_data_out,
    output logic        m_data_valid
);

    // Which read register feeds data_out for the pending result.
    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_STACK  = 2'd1,
        SRC_LINE_A = 2'd2,
        SRC_LINE_B = 2'd3
    } src_t;

    logic                   accept;
    cmd_t                   cmd;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [VALUE_WIDTH-1:0] held_cur;
    logic [VALUE_WIDTH-1:0] out_val;

    logic                   push_en;
    logic                   pop_en;
    logic                   enq_a;
    logic                   enq_b;
    logic                   deq_a;
    logic                   deq_b;

    logic [VALUE_WIDTH-1:0] stack_rdata;
    logic [VALUE_WIDTH-1:0] line_a_rdata;
    logic [VALUE_WIDTH-1:0] line_b_rdata;
    fill_t                  stack_fill;
    fill_t                  line_a_fill;
    fill_t                  line_b_fill;
    fill_t                  line_fill;

    status_t                status_next;
    src_t                   src_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    status_t                status_reg;
    src_t                   src_reg;
    logic [VALUE_WIDTH-1:0] held_reg;
    logic                   held_pend_reg;

    // Take a new request whenever the result slot is free or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_cmd);
    assign in_val  = VALUE_WIDTH'(s_plate_value);

    // A pop lands its value in the stack read register; fold it into the
    // held register at the next accepted request.
    assign held_cur  = held_pend_reg ? stack_rdata : held_reg;
    assign line_fill = s_line_select ? line_b_fill : line_a_fill;

    assign push_en = accept && (cmd == CMD_PUSH) && !stack_fill.full;
    assign pop_en  = accept && (cmd == CMD_POP) && !stack_fill.empty;
    assign enq_a   = accept && (cmd == CMD_ENQ) && !s_line_select && !line_a_fill.full;
    assign enq_b   = accept && (cmd == CMD_ENQ) && s_line_select && !line_b_fill.full;
    assign deq_a   = accept && (cmd == CMD_DEQ) && !s_line_select && !line_a_fill.empty;
    assign deq_b   = accept && (cmd == CMD_DEQ) && s_line_select && !line_b_fill.empty;

    // Decode status and data source for the result.
    always_comb begin
        status_next = ST_OK;
        src_next    = SRC_NONE;
        case (cmd)
            CMD_PUSH: begin
                if (stack_fill.full) begin
                    status_next = ST_FULL;
                end
            end
            CMD_POP: begin
                if (stack_fill.empty) begin
                    status_next = ST_STACK_EMPTY;
                end else begin
                    src_next = SRC_STACK;
                end
            end
            CMD_ENQ: begin
                if (line_fill.full) begin
                    status_next = ST_FULL;
                end
            end
            CMD_DEQ: begin
                if (line_fill.empty) begin
                    status_next = ST_LINE_EMPTY;
                end else begin
                    src_next = s_line_select ? SRC_LINE_B : SRC_LINE_A;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            status_reg    <= ST_OK;
            src_reg       <= SRC_NONE;
            held_reg      <= '0;
            held_pend_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                status_reg    <= status_next;
                src_reg       <= src_next;
                held_reg      <= held_cur;
                held_pend_reg <= pop_en;
            end
        end
    end

    sltq_stack #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_en (push_en),
        .pop_en  (pop_en),
        .wdata   (in_val),
        .rdata   (stack_rdata),
        .fill    (stack_fill)
    );

    sltq_line #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_line_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enq_en  (enq_a),
        .deq_en  (deq_a),
        .wdata   (held_cur),
        .rdata   (line_a_rdata),
        .fill    (line_a_fill)
    );

    sltq_line #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_line_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enq_en  (enq_b),
        .deq_en  (deq_b),
        .wdata   (held_cur),
        .rdata   (line_b_rdata),
        .fill    (line_b_fill)
    );

    // Select the read register for the pending result; zero when none.
    always_comb begin
        case (src_reg)
            SRC_STACK:  out_val = stack_rdata;
            SRC_LINE_A: out_val = line_a_rdata;
            SRC_LINE_B: out_val = line_b_rdata;
            default:    out_val = '0;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_data_out   = 16'(out_val);
    assign m_data_valid = (src_reg != SRC_NONE);

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request taken while result stalled");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |=> !stack_fill.empty)
        else $error("stack empty after successful push");

    a_data_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data_valid) |-> (m_status == ST_OK))
        else $error("data valid with failing status");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import sltq_pkg::*;
();

    localparam logic LINE_A = 1'b0;
    localparam logic LINE_B = 1'b1;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTS  = 20;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        status_t     status;
        logic [15:0] data;
        logic        valid;
        int          seq;
    } plate_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = 2'd0;
    logic        s_line_select = 1'b0;
    logic [15:0] s_plate_value = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_data_out;
    logic        m_data_valid;

    // Idling mix of the current phase, in percent of cycles.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic rx_hold = 1'b0;

    int err_count = 0;
    int req_count = 0;
    int checked_count = 0;
    int cycle_count = 0;

    // Shadow copy of the stack, the held register and both lines.
    logic [15:0] stack_mem [STACK_DEPTH_DEF];
    int          stack_used = 0;
    logic [15:0] held_value = 16'd0;
    logic [15:0] line_mem [2][LINE_DEPTH_DEF];
    int          line_head [2] = '{0, 0};
    int          line_tail [2] = '{0, 0};
    int          line_fill [2] = '{0, 0};

    plate_result_t awaited_results [$];

    stack_and_two_line_queue_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_line_select (s_line_select),
        .s_plate_value (s_plate_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data_out    (m_data_out),
        .m_data_valid  (m_data_valid)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: stall at the phase rate, hold off completely while rx_hold is set.
    always @(posedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int seq,
                                   input logic [15:0] got, input logic [15:0] want);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH request %0d: %s got %h expected %h", seq, what, got, want);
        err_count++;
    endtask

    // Apply one command to the shadow state and return the result it must produce.
    function automatic plate_result_t apply_command(input cmd_t cmd, input logic sel,
                                                    input logic [15:0] value);
        plate_result_t res;
        res.status = ST_OK;
        res.data   = 16'd0;
        res.valid  = 1'b0;
        res.seq    = req_count;
        case (cmd)
            CMD_PUSH: begin
                if (stack_used >= STACK_DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    stack_mem[stack_used] = value;
                    stack_used++;
                end
            end
            CMD_POP: begin
                if (stack_used == 0) begin
                    res.status = ST_STACK_EMPTY;
                end else begin
                    stack_used--;
                    held_value = stack_mem[stack_used];
                    res.data   = held_value;
                    res.valid  = 1'b1;
                end
            end
            CMD_ENQ: begin
                if (line_fill[sel] >= LINE_DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    line_mem[sel][line_tail[sel]] = held_value;
                    line_tail[sel] = (line_tail[sel] + 1) % LINE_DEPTH_DEF;
                    line_fill[sel]++;
                end
            end
            default: begin
                if (line_fill[sel] == 0) begin
                    res.status = ST_LINE_EMPTY;
                end else begin
                    res.data  = line_mem[sel][line_head[sel]];
                    res.valid = 1'b1;
                    line_head[sel] = (line_head[sel] + 1) % LINE_DEPTH_DEF;
                    line_fill[sel]--;
                end
            end
        endcase
        return res;
    endfunction

    // Offer one request, hold it until accepted, then record what it must return.
    // Valid is only dropped during an idle gap, never lowered and raised in one step.
    task automatic send_request(input cmd_t cmd, input logic sel,
                                input logic [15:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_line_select <= sel;
        s_plate_value <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        awaited_results.push_back(apply_command(cmd, sel, value));
        req_count++;
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    // Compare each accepted result against the oldest outstanding expectation.
    always @(posedge aclk) begin
        plate_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, data", -1, m_data_out, 16'd0);
            end else begin
                want = awaited_results.pop_front();
                checked_count++;
                if (m_status !== want.status)
                    report_mismatch("status", want.seq, 16'(m_status), 16'(want.status));
                if (m_data_out !== want.data)
                    report_mismatch("data_out", want.seq, m_data_out, want.data);
                if (m_data_valid !== want.valid)
                    report_mismatch("data_valid", want.seq, 16'(m_data_valid),
                                    16'(want.valid));
            end
        end
    end

    // Empty structures right after reset, and enqueue of the reset held value.
    task automatic test_empty_after_reset();
        send_request(CMD_POP, LINE_A, 16'h1234);
        send_request(CMD_DEQ, LINE_A, 16'h0000);
        send_request(CMD_DEQ, LINE_B, 16'hFFFF);
        send_request(CMD_ENQ, LINE_A, 16'hABCD);
        send_request(CMD_DEQ, LINE_A, 16'h0000);
        drain_results();
    endtask

    // LIFO order, field extremes, held value carried into both lines.
    task automatic test_lifo_and_lines();
        send_request(CMD_PUSH, LINE_A, 16'hFFFF);
        send_request(CMD_PUSH, LINE_B, 16'h0000);
        send_request(CMD_PUSH, LINE_B, 16'h5AA5);
        send_request(CMD_POP, LINE_B, 16'hFFFF);
        send_request(CMD_POP, LINE_A, 16'h0000);
        send_request(CMD_ENQ, LINE_B, 16'h0000);
        send_request(CMD_POP, LINE_A, 16'hA55A);
        send_request(CMD_ENQ, LINE_B, 16'hFFFF);
        send_request(CMD_ENQ, LINE_A, 16'h0000);
        send_request(CMD_DEQ, LINE_B, 16'hFFFF);
        send_request(CMD_DEQ, LINE_B, 16'h0000);
        send_request(CMD_DEQ, LINE_A, 16'hFFFF);
        send_request(CMD_DEQ, LINE_B, 16'h0000);
        send_request(CMD_POP, LINE_B, 16'hFFFF);
        drain_results();
    endtask

    // Fill the stack to the top, overflow it, then pop it empty and underflow.
    task automatic test_stack_full();
        while (stack_used < STACK_DEPTH_DEF)
            send_request(CMD_PUSH, 1'($urandom_range(0, 1)), 16'($urandom));
        send_request(CMD_PUSH, LINE_A, 16'($urandom));
        while (stack_used > 0)
            send_request(CMD_POP, 1'($urandom_range(0, 1)), 16'($urandom));
        send_request(CMD_POP, LINE_B, 16'($urandom));
        drain_results();
    endtask

    // Fill one line to capacity with changing held values, then overflow it.
    task automatic test_line_full(input logic sel);
        int n;
        n = 0;
        while (line_fill[sel] < LINE_DEPTH_DEF) begin
            if (n % 8 == 0) begin
                send_request(CMD_PUSH, sel, 16'($urandom));
                send_request(CMD_POP, sel, 16'($urandom));
            end
            send_request(CMD_ENQ, sel, 16'($urandom));
            n++;
        end
        send_request(CMD_ENQ, sel, 16'($urandom));
        drain_results();
    endtask

    // Random command stream; the mix swings between filling and draining so
    // that stack and line counts rise and fall.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int   r;
        logic filling;
        cmd_t cmd;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        filling = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 24)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (filling)
                cmd = (r < 35) ? CMD_PUSH : (r < 55) ? CMD_POP :
                      (r < 85) ? CMD_ENQ : CMD_DEQ;
            else
                cmd = (r < 15) ? CMD_PUSH : (r < 45) ? CMD_POP :
                      (r < 60) ? CMD_ENQ : CMD_DEQ;
            send_request(cmd, 1'($urandom_range(0, 1)), 16'($urandom));
        end
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the block fills up and drops s_ready.
    task automatic test_backpressure_hold();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 30; i++)
            send_request(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         16'($urandom));
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_after_reset();
        test_lifo_and_lines();
        test_stack_full();
        test_line_full(LINE_A);
        test_line_full(LINE_B);
        test_backpressure_hold();
        test_random_traffic(50, 0, 0);
        test_random_traffic(50, 47, 0);
        test_random_traffic(50, 0, 47);
        test_random_traffic(50, 27, 27);

        // Let any straggling result surface before the final tally.
        drain_results();
        repeat (10) @(posedge aclk);
        if (awaited_results.size() != 0)
            report_mismatch("results never returned, count", -1,
                            16'(awaited_results.size()), 16'd0);

        $display("Sent %0d requests and checked %0d results over four idling mixes,",
                 req_count, checked_count);
        $display("stack and line overflow, underflow, pointer wrap and a long result stall.");
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
